// File: rtl/core/hcsp_pkg.sv
// Package for the hex color string parser: parse phases, status codes,
// character constants and the request/result structs.
// No dependencies.
package hcsp_pkg;

    localparam int unsigned MAX_CHARS = 31;
    localparam int unsigned COUNT_W   = 6;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_HEX    = 3'd1,
        PH_PREFIX = 3'd2,
        PH_RGB    = 3'd3,
        PH_DONE   = 3'd4,
        PH_LONG   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOT_HEX = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_char;
    } char_req_t;

    typedef struct packed {
        logic [23:0] color;
        logic [1:0]  status;
    } color_res_t;

endpackage

// File: rtl/core/hcsp_in_stage.sv
// Input register for one character request, with the stream handshake.
// Depends on hcsp_pkg.
module hcsp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hcsp_pkg::char_req_t in_req,
    input  logic               out_room,
    output logic               take,
    output hcsp_pkg::char_req_t req
);
    import hcsp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    char_req_t req_reg;

    // a character that closes a string needs a free result slot
    assign take     = valid_reg && (!req_reg.last_char || out_room);
    assign in_ready = !valid_reg || take;
    assign req      = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg <= in_req;
        end
    end

endmodule

// File: rtl/core/hcsp_parse_core.sv
// Parse state registers and the per-character update; produces the result
// for the final character of a string. Depends on hcsp_pkg.
module hcsp_parse_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  hcsp_pkg::char_req_t  req,
    output logic                 res_valid,
    output hcsp_pkg::color_res_t res
);
    import hcsp_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    phase_t             phase_reg, phase_next;
    logic [23:0]        hex_reg, hex_next;
    logic [5:0]         digits_reg, digits_next;
    logic [23:0]        comp_reg, comp_next;
    logic [1:0]         idx_reg, idx_next;
    logic [1:0]         ccnt_reg, ccnt_next;
    logic               bad_reg, bad_next;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c >= "a" && c <= "f")
        begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    function automatic logic [23:0] finish_accum(input logic [23:0] a, input logic [1:0] n);
        logic [23:0] r;
        r = a;
        if (n == 2'd0)
        begin
            r = {a[15:0], 8'h00};
        end
        else if (n == 2'd1)
        begin
            r = {a[19:0], a[3:0]};
        end
        return r;
    endfunction

    function automatic logic [23:0] swap_rb(input logic [23:0] v);
        return {v[7:0], v[15:8], v[23:16]};
    endfunction

    logic [7:0]  c;
    logic [4:0]  hv;
    logic        do_feed;
    logic        feed_first;
    logic        do_push;
    logic        push_hash_ok;
    logic        first0;
    logic [7:0]  expect_ch;
    logic        use_rgb;
    logic        fin_bad;
    logic [23:0] fin_comp;
    logic [23:0] v;
    logic [1:0]  status;
    logic [23:0] color;

    always_comb
    begin
        c = req.ch;
        if (req.ch >= "A" && req.ch <= "Z")
        begin
            c = req.ch + CASE_GAP;
        end
        hv = hex_val(c);

        count_next  = count_reg;
        phase_next  = phase_reg;
        hex_next    = hex_reg;
        digits_next = digits_reg;
        comp_next   = comp_reg;
        idx_next    = idx_reg;
        ccnt_next   = ccnt_reg;
        bad_next    = bad_reg;

        do_feed      = 1'b0;
        feed_first   = 1'b0;
        do_push      = 1'b0;
        push_hash_ok = 1'b0;
        first0       = (idx_reg == 2'd0) && (ccnt_reg == 2'd0);
        expect_ch    = CH_COLON;
        if (ccnt_reg == 2'd1)
        begin
            expect_ch = CH_G;
        end
        else if (ccnt_reg == 2'd2)
        begin
            expect_ch = CH_B;
        end

        if (phase_reg != PH_LONG)
        begin
            if (count_reg >= COUNT_W'(MAX_CHARS))
            begin
                phase_next = PH_LONG;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                case (phase_reg)
                    PH_START:
                    begin
                        if (c == CH_R)
                        begin
                            phase_next = PH_PREFIX;
                            ccnt_next  = 2'd1;
                        end
                        else
                        begin
                            do_feed    = 1'b1;
                            feed_first = 1'b1;
                            phase_next = PH_HEX;
                        end
                    end
                    PH_HEX:
                    begin
                        do_feed = 1'b1;
                    end
                    PH_PREFIX:
                    begin
                        if (c != expect_ch)
                        begin
                            bad_next   = 1'b1;
                            phase_next = PH_HEX;
                        end
                        else if (ccnt_reg == 2'd3)
                        begin
                            phase_next  = PH_RGB;
                            ccnt_next   = 2'd0;
                            idx_next    = 2'd0;
                            comp_next   = 24'd0;
                            hex_next    = 24'd0;
                            digits_next = 6'd0;
                        end
                        else
                        begin
                            ccnt_next = ccnt_reg + 1'b1;
                        end
                    end
                    PH_RGB:
                    begin
                        if (c == CH_SLASH)
                        begin
                            comp_next = finish_accum(comp_reg, ccnt_reg);
                            if (ccnt_reg == 2'd1 && idx_reg == 2'd0 && digits_reg == 6'd0)
                            begin
                                bad_next = 1'b1;
                            end
                            if (idx_reg >= 2'd2)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                idx_next  = idx_reg + 1'b1;
                                ccnt_next = 2'd0;
                            end
                        end
                        else if (ccnt_reg >= 2'd2)
                        begin
                            if (idx_reg == 2'd0)
                            begin
                                do_feed = 1'b1;
                            end
                            else
                            begin
                                bad_next = 1'b1;
                            end
                            phase_next = PH_HEX;
                        end
                        else
                        begin
                            do_feed      = (idx_reg == 2'd0);
                            feed_first   = first0;
                            do_push      = 1'b1;
                            push_hash_ok = first0;
                            ccnt_next    = ccnt_reg + 1'b1;
                            if (idx_reg >= 2'd2 && ccnt_reg == 2'd1)
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // hex digit path, with an optional leading '#'
        if (do_feed && !(feed_first && c == CH_HASH))
        begin
            if (!hv[4])
            begin
                bad_next = 1'b1;
            end
            else
            begin
                hex_next = {hex_reg[19:0], hv[3:0]};
                if (digits_reg != 6'd63)
                begin
                    digits_next = digits_reg + 1'b1;
                end
            end
        end

        // component path: a '#' is accepted, as a zero digit, only at the first position
        if (do_push)
        begin
            if (!hv[4] && !(push_hash_ok && c == CH_HASH))
            begin
                bad_next = 1'b1;
            end
            comp_next = {comp_reg[19:0], hv[4] ? hv[3:0] : 4'h0};
        end

        // close the string
        use_rgb  = 1'b0;
        status   = ST_OK;
        color    = 24'd0;
        fin_bad  = bad_next;
        fin_comp = comp_next;
        case (phase_next)
            PH_LONG:
            begin
                status = ST_TOO_LONG;
            end
            PH_PREFIX:
            begin
                status = ST_NOT_HEX;
            end
            PH_RGB:
            begin
                if (idx_next == 2'd1)
                begin
                    status = ST_NOT_HEX;
                end
                else if (idx_next >= 2'd2)
                begin
                    fin_comp = finish_accum(comp_next, ccnt_next);
                    use_rgb  = 1'b1;
                end
            end
            PH_DONE:
            begin
                use_rgb = 1'b1;
            end
            default:
            begin
            end
        endcase

        v = hex_next;
        if (digits_next == 6'd3)
        begin
            v = {hex_next[11:8], hex_next[11:8], hex_next[7:4],
                 hex_next[7:4], hex_next[3:0], hex_next[3:0]};
        end
        if (status == ST_OK)
        begin
            if (fin_bad)
            begin
                status = ST_NOT_HEX;
            end
            else if (use_rgb)
            begin
                color = swap_rb(fin_comp);
            end
            else
            begin
                color = swap_rb(v);
            end
        end

        res.color  = color;
        res.status = status;
        res_valid  = take && req.last_char;

        // a finished string returns every register to its start value
        if (req.last_char)
        begin
            count_next  = '0;
            phase_next  = PH_START;
            hex_next    = 24'd0;
            digits_next = 6'd0;
            comp_next   = 24'd0;
            idx_next    = 2'd0;
            ccnt_next   = 2'd0;
            bad_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            phase_reg  <= PH_START;
            hex_reg    <= 24'd0;
            digits_reg <= 6'd0;
            comp_reg   <= 24'd0;
            idx_reg    <= 2'd0;
            ccnt_reg   <= 2'd0;
            bad_reg    <= 1'b0;
        end
        else if (take)
        begin
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            hex_reg    <= hex_next;
            digits_reg <= digits_next;
            comp_reg   <= comp_next;
            idx_reg    <= idx_next;
            ccnt_reg   <= ccnt_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

// File: rtl/core/hcsp_out_stage.sv
// Result register on the output stream.
// Depends on hcsp_pkg.
module hcsp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  hcsp_pkg::color_res_t res,
    output logic                 out_room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hcsp_pkg::color_res_t out_res
);
    import hcsp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    color_res_t res_reg;

    assign out_room  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// File: rtl/core/hex_color_string_parser.sv
// Top level of the hex color string parser: input register, parse core and
// result register. Depends on hcsp_pkg, hcsp_in_stage, hcsp_parse_core, hcsp_out_stage.
//
//   stream   | dir | tdata                 | tuser        | tlast
//   s_axis   | in  | [7:0] ch              | -            | last_char
//   m_axis   | out | [23:0] color (B,G,R)  | [1:0] status | -
//
// One character per cycle unless m_axis holds back a final character; the result for
// a string passes the input register, then the result register.
// The per-character state update is one short combinational step in the core.
// Reset clears the parse state and both valid flags.
// A stalled m_axis holds only a final character; other characters keep flowing.
module hex_color_string_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] color
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import hcsp_pkg::*;

    char_req_t  in_req;
    char_req_t  req;
    color_res_t res;
    color_res_t out_res;
    logic       take;
    logic       out_room;
    logic       res_valid;

    assign in_req.ch        = s_axis_tdata;
    assign in_req.last_char = s_axis_tlast;

    hcsp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (in_req),
        .out_room (out_room),
        .take     (take),
        .req      (req)
    );

    hcsp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    hcsp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_room  (out_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.color;
    assign m_axis_tuser = out_res.status;

endmodule

// File: rtl/core/hcsp_checker.sv
// Port-level checks for hex_color_string_parser, attached by bind.
// Depends on hcsp_pkg.
module hcsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import hcsp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_NOT_HEX ||
                           m_axis_tuser == ST_TOO_LONG))
        else $error("undefined status code");

    a_error_color: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == 24'd0)
        else $error("nonzero color with error status");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a final character two cycles earlier");

endmodule

bind hex_color_string_parser hcsp_checker u_hcsp_checker (.*);

// File: verif/hex_color_string_parser_test.sv
// Testbench for hex_color_string_parser: drives color strings one character per
// request, predicts each parsed color and status, and checks every result.
// Depends on hcsp_pkg and the hex_color_string_parser RTL.
module hex_color_string_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hcsp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned RANDOM_CHARS = 600;
    localparam logic [7:0]  CH_0  = 8'h30;
    localparam logic [7:0]  CH_9  = 8'h39;
    localparam logic [7:0]  CH_LA = 8'h61;
    localparam logic [7:0]  CH_LF = 8'h66;
    localparam logic [7:0]  CH_LZ = 8'h7a;
    localparam logic [7:0]  CH_UA = 8'h41;
    localparam logic [7:0]  CH_UZ = 8'h5a;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // parse state of the predictor
    logic [5:0]  n_chars;
    phase_t      phase;
    logic [23:0] hex_acc;
    logic [5:0]  hex_count;
    logic [23:0] comp_acc;
    logic [1:0]  comp_idx;
    logic [1:0]  comp_len;
    logic        saw_bad;

    color_res_t  expected_colors[$];
    logic [7:0]  line_buf[$];
    int          errors = 0;
    int          chars_sent = 0;
    int          cycles = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b1;
    bit          hold_go = 1'b0;
    logic        hold_active = 1'b0;

    hex_color_string_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("hex_color_string_parser: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        n_chars   = '0;
        phase     = PH_START;
        hex_acc   = '0;
        hex_count = '0;
        comp_acc  = '0;
        comp_idx  = '0;
        comp_len  = '0;
        saw_bad   = 1'b0;
    endfunction

    function automatic int nibble_of(logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF)
            return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    function automatic void hex_take(logic [7:0] c, bit first);
        int v;
        if (first && c == CH_HASH)
            return;
        v = nibble_of(c);
        if (v < 0)
        begin
            saw_bad = 1'b1;
            return;
        end
        hex_acc = {hex_acc[19:0], 4'(v)};
        if (hex_count < 6'd63)
            hex_count = hex_count + 6'd1;
    endfunction

    function automatic void comp_take(logic [7:0] c, bit hash_ok);
        int v;
        logic [3:0] d;
        v = nibble_of(c);
        d = 4'h0;
        if (v >= 0)
            d = 4'(v);
        else if (!(hash_ok && c == CH_HASH))
            saw_bad = 1'b1;
        comp_acc = {comp_acc[19:0], d};
    endfunction

    function automatic void comp_close();
        if (comp_len == 2'd0)
            comp_acc = {comp_acc[15:0], 8'h00};
        else if (comp_len == 2'd1)
        begin
            // a lone '#' as the whole first component carries no digit
            if (comp_idx == 2'd0 && hex_count == 6'd0)
                saw_bad = 1'b1;
            comp_acc = {comp_acc[19:0], comp_acc[3:0]};
        end
    endfunction

    function automatic logic [23:0] swap_rb(logic [23:0] v);
        return {v[7:0], v[15:8], v[23:16]};
    endfunction

    function automatic void parse_char(logic [7:0] c);
        int n;
        bit first0;
        logic [7:0] want_ch;
        n = comp_len;
        case (phase)
            PH_START:
            begin
                if (c == CH_R)
                begin
                    phase = PH_PREFIX;
                    comp_len = 2'd1;
                end
                else
                begin
                    hex_take(c, 1'b1);
                    phase = PH_HEX;
                end
            end
            PH_HEX:
                hex_take(c, 1'b0);
            PH_PREFIX:
            begin
                want_ch = (n == 1) ? CH_G : (n == 2) ? CH_B : CH_COLON;
                if (c != want_ch)
                begin
                    saw_bad = 1'b1;
                    phase = PH_HEX;
                end
                else if (n >= 3)
                begin
                    phase = PH_RGB;
                    comp_len = '0;
                    comp_idx = '0;
                    comp_acc = '0;
                    hex_acc = '0;
                    hex_count = '0;
                end
                else
                    comp_len = 2'(n + 1);
            end
            PH_RGB:
            begin
                if (c == CH_SLASH)
                begin
                    comp_close();
                    if (comp_idx >= 2'd2)
                        phase = PH_DONE;
                    else
                    begin
                        comp_idx = comp_idx + 2'd1;
                        comp_len = '0;
                    end
                end
                else if (n >= 2)
                begin
                    // over-long component: fall back to plain hex (invalid unless in the first component)
                    if (comp_idx == 2'd0)
                        hex_take(c, 1'b0);
                    else
                        saw_bad = 1'b1;
                    phase = PH_HEX;
                end
                else
                begin
                    first0 = (comp_idx == 2'd0 && n == 0);
                    if (comp_idx == 2'd0)
                        hex_take(c, first0);
                    comp_take(c, first0);
                    comp_len = 2'(n + 1);
                    if (comp_idx >= 2'd2 && n + 1 >= 2)
                        phase = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic bit color_parse_step(input logic [7:0] raw, input logic last,
                                            output color_res_t res);
        logic [7:0]  c;
        logic [31:0] v;
        bit          use_rgb;
        status_t     st;
        c = raw;
        if (c >= CH_UA && c <= CH_UZ)
            c = c + CASE_GAP;
        if (phase != PH_LONG)
        begin
            if (n_chars >= MAX_CHARS)
                phase = PH_LONG;
            else
            begin
                n_chars = n_chars + 6'd1;
                parse_char(c);
            end
        end
        res = '0;
        if (!last)
            return 1'b0;
        st = ST_OK;
        use_rgb = 1'b0;
        case (phase)
            PH_LONG:
                st = ST_TOO_LONG;
            PH_PREFIX:
                st = ST_NOT_HEX;
            PH_RGB:
            begin
                if (comp_idx == 2'd1)
                    st = ST_NOT_HEX;
                else if (comp_idx >= 2'd2)
                begin
                    comp_close();
                    use_rgb = 1'b1;
                end
            end
            PH_DONE:
                use_rgb = 1'b1;
            default:
            begin
            end
        endcase
        if (st == ST_OK)
        begin
            if (saw_bad)
                st = ST_NOT_HEX;
            else if (use_rgb)
                res.color = swap_rb(comp_acc);
            else
            begin
                v = {8'h00, hex_acc};
                // three digits: abc -> aabbcc
                if (hex_count == 6'd3)
                    v = ((v & 32'hF00) << 12) | ((v & 32'hFF0) << 8)
                      | ((v & 32'h0FF) << 4) | (v & 32'h00F);
                res.color = swap_rb(v[23:0]);
            end
        end
        res.status = st;
        clear_parse();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_active)
            m_axis_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // long receiver hold-off, counted here
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        color_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_colors.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result color=%06h status=%0d",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = expected_colors.pop_front();
                if (m_axis_tdata !== want.color)
                begin
                    errors++;
                    $display("%0t: color expected %06h actual %06h",
                             $time, want.color, m_axis_tdata);
                end
                if (m_axis_tuser !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic last);
        color_res_t res;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
        if (color_parse_step(c, last, res))
            expected_colors.push_back(res);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
        send_line();
    endtask

    function automatic logic [7:0] any_case(logic [7:0] c);
        if (c >= CH_LA && c <= CH_LZ && $urandom_range(0, 1))
            return c - CASE_GAP;
        return c;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10)
            return CH_0 + 8'(d);
        return any_case(CH_LA + 8'(d - 10));
    endfunction

    function automatic void add_hex_run(int n);
        int k;
        for (k = 0; k < n; k++)
            line_buf.push_back(rand_hex_char());
    endfunction

    function automatic void build_hex_string();
        int n;
        if ($urandom_range(0, 1))
            line_buf.push_back(CH_HASH);
        case ($urandom_range(0, 3))
            0: n = 3;
            1: n = 6;
            default: n = $urandom_range(0, 10);
        endcase
        add_hex_run(n);
        if (line_buf.size() == 0 || $urandom_range(0, 9) == 0)
        begin
            if (line_buf.size() == 0)
                line_buf.push_back(8'($urandom_range(0, 255)));
            else
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic void build_rgb_string();
        int comps, k, j, len, pick;
        line_buf.push_back(any_case(CH_R));
        line_buf.push_back(any_case(CH_G));
        line_buf.push_back(any_case(CH_B));
        line_buf.push_back(CH_COLON);
        if ($urandom_range(0, 11) == 0)
            line_buf[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
        comps = $urandom_range(1, 4);
        for (k = 0; k < comps; k++)
        begin
            if (k > 0)
                line_buf.push_back(CH_SLASH);
            pick = $urandom_range(0, 9);
            len = (pick == 0) ? 0 : (pick < 5) ? 1 : (pick < 9) ? 2 : 3;
            for (j = 0; j < len; j++)
            begin
                if (k == 0 && j == 0 && $urandom_range(0, 7) == 0)
                    line_buf.push_back(CH_HASH);
                else
                    line_buf.push_back(rand_hex_char());
            end
        end
        if ($urandom_range(0, 7) == 0)
            line_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_noise();
        int n, k;
        n = $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0)
            line_buf.push_back(any_case(CH_R));
        for (k = 0; k < n; k++)
            line_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_hex_forms();
        send_text("#000000");
        send_text("FFFFFF");
        send_text("#aBc");
        send_text("1234567890");
        send_text("#");
    endtask

    task automatic test_rgb_forms();
        send_text("rgb:12/34/56");
        send_text("RGB:a/B/c");
        send_text("rgb://");
        send_text("rgb:#1/2/3");
        send_text("rgb:12/34/56/zz");
        send_text("rgb:1234");
        send_text("rgb:5");
        send_text("rgb:1/2");
        send_text("rgb:1/234");
        send_text("rgb:#");
        send_text("rgb:");
    endtask

    task automatic test_not_hex();
        send_text("red");
        send_text("rg");
        send_text("#12g4");
        send_text("##1");
        send_text("rgb:##");
        // NUL does not end the string
        line_buf.push_back(CH_LA);
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hff);
        send_line();
    endtask

    task automatic test_too_long();
        add_hex_run(MAX_CHARS);
        send_line();
        add_hex_run(MAX_CHARS + 1);
        send_line();
        line_buf.push_back(CH_R);
        add_hex_run(62);
        send_line();
    endtask

    task automatic test_output_stall();
        int k;
        idle_on = 1'b0;
        hold_go = 1'b1;
        // keep offering short strings while the results are held off
        for (k = 0; k < 30; k++)
        begin
            if (k % 2)
                build_rgb_string();
            else
                build_hex_string();
            send_line();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random_strings(input int n_send);
        int stop_at, pick;
        stop_at = chars_sent + n_send;
        while (chars_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                build_hex_string();
            else if (pick < 82)
                build_rgb_string();
            else if (pick < 94)
                build_noise();
            else
                add_hex_run($urandom_range(28, 45));
            send_line();
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        test_random_strings(150);
    endtask

    initial
    begin
        clear_parse();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hex_forms();
        test_rgb_forms();
        test_not_hex();
        test_too_long();
        test_random_strings(RANDOM_CHARS / 2);
        test_output_stall();
        test_random_strings(RANDOM_CHARS / 2);
        test_steady_stream();

        s_axis_tvalid <= 1'b0;
        wait (expected_colors.size() == 0);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("hex_color_string_parser: match");
        else
            $display("hex_color_string_parser: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/hcsp_pkg.sv
rtl/core/hcsp_in_stage.sv
rtl/core/hcsp_parse_core.sv
rtl/core/hcsp_out_stage.sv
rtl/core/hex_color_string_parser.sv
rtl/core/hcsp_checker.sv
verif/hex_color_string_parser_test.sv
